// ===== design/smx_pkg.sv =====
package smx_pkg;

    localparam int unsigned WordWidth  = 16;
    localparam int unsigned DepthWidth = 9;

    typedef logic [WordWidth-1:0]  t_word;
    typedef logic [7:0]            t_opcode;
    typedef logic [DepthWidth-1:0] t_depth;

    localparam t_opcode OP_PUSH = 8'd0;
    localparam t_opcode OP_POP  = 8'd1;
    localparam t_opcode OP_ADD  = 8'd2;
    localparam t_opcode OP_SUB  = 8'd3;
    localparam t_opcode OP_MUL  = 8'd4;
    localparam t_opcode OP_INC  = 8'd5;
    localparam t_opcode OP_DEC  = 8'd6;
    localparam t_opcode OP_HALT = 8'd7;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_ILLEGAL   = 3'd3,
        ST_IGNORED   = 3'd4
    } t_status;

    // How the cached top, the cached entry below it and the stack pointer move.
    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_PUSH,
        ACT_POP,
        ACT_REDUCE,
        ACT_MODIFY,
        ACT_HALT
    } t_stack_act;

    typedef struct packed {
        logic empty;
        logic has_two;
        logic full;
        logic halted;
    } t_stack_flags;

    typedef struct packed {
        t_stack_act act;
        t_word      value;
        t_status    status;
    } t_exec_res;

endpackage

// ===== design/smx_stack_ram.sv =====
module smx_stack_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  smx_pkg::t_word   i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output smx_pkg::t_word   o_rd_data
);
    import smx_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/smx_alu.sv =====
module smx_alu (
    input  smx_pkg::t_opcode     i_opcode,
    input  smx_pkg::t_word       i_immediate,
    input  smx_pkg::t_word       i_top,
    input  smx_pkg::t_word       i_below,
    input  smx_pkg::t_stack_flags i_flags,
    output smx_pkg::t_exec_res   o_res
);
    import smx_pkg::*;

    logic [2*WordWidth-1:0] w_product;

    assign w_product = i_below * i_top;

    always_comb begin
        o_res.act    = ACT_HOLD;
        o_res.value  = '0;
        o_res.status = ST_OK;
        if (i_flags.halted) begin
            o_res.status = ST_IGNORED;
        end else begin
            unique case (i_opcode)
                OP_PUSH: begin
                    if (i_flags.full) begin
                        o_res.status = ST_OVERFLOW;
                    end else begin
                        o_res.act   = ACT_PUSH;
                        o_res.value = i_immediate;
                    end
                end
                OP_POP: begin
                    if (i_flags.empty) begin
                        o_res.status = ST_UNDERFLOW;
                    end else begin
                        o_res.act   = ACT_POP;
                        o_res.value = i_top;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL: begin
                    if (!i_flags.has_two) begin
                        o_res.status = ST_UNDERFLOW;
                    end else begin
                        o_res.act = ACT_REDUCE;
                        if (i_opcode == OP_ADD) begin
                            o_res.value = i_below + i_top;
                        end else if (i_opcode == OP_SUB) begin
                            o_res.value = i_below - i_top;
                        end else begin
                            o_res.value = w_product[WordWidth-1:0];
                        end
                    end
                end
                OP_INC, OP_DEC: begin
                    if (i_flags.empty) begin
                        o_res.status = ST_UNDERFLOW;
                    end else begin
                        o_res.act   = ACT_MODIFY;
                        o_res.value = (i_opcode == OP_INC) ? i_top + 16'd1 : i_top - 16'd1;
                    end
                end
                OP_HALT: begin
                    o_res.act = ACT_HALT;
                end
                default: begin
                    o_res.status = ST_ILLEGAL;
                end
            endcase
        end
    end

endmodule

// ===== design/stack_machine_executor.sv =====
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_opcode, i_immediate
// result    out        o_out_valid / i_out_stall  o_result_value, o_depth, o_halted, o_status
//
// One instruction per cycle unless stalled; each result is valid in the cycle after acceptance.
// The top two stack entries live in registers; deeper entries sit in a RAM whose
// registered read always prefetches the third entry, with a bypass for a fresh push.
// Synchronous active-low reset empties the stack and clears the halt flag.
// A request is taken while a result waits unless the downstream side stalls.
module stack_machine_executor #(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  smx_pkg::t_opcode    i_opcode,
    input  smx_pkg::t_word      i_immediate,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output smx_pkg::t_word      o_result_value,
    output smx_pkg::t_depth     o_depth,
    output logic                o_halted,
    output smx_pkg::t_status    o_status
);
    import smx_pkg::*;

    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW  = $clog2(STACK_DEPTH);

    logic [SPW-1:0] r_sp, n_sp;
    logic           r_halted, n_halted;
    t_word          r_top, n_top;
    t_word          r_below, n_below;
    logic           r_byp, n_byp;
    t_word          r_byp_data;
    logic           r_out_valid, n_out_valid;
    t_word          r_value;
    t_status        r_status;

    t_stack_flags   w_flags;
    t_exec_res      w_res;
    logic           w_accept;
    logic           w_we;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;
    t_word          w_rd_data;
    t_word          w_third;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_flags.empty   = (r_sp == '0);
    assign w_flags.has_two = (r_sp >= SPW'(2));
    assign w_flags.full    = (r_sp == SPW'(STACK_DEPTH));
    assign w_flags.halted  = r_halted;

    smx_alu u_alu (
        .i_opcode    (i_opcode),
        .i_immediate (i_immediate),
        .i_top       (r_top),
        .i_below     (r_below),
        .i_flags     (w_flags),
        .o_res       (w_res)
    );

    // The entry third from the top; the bypass copy is used when a push in the previous cycle wrote it.
    assign w_third = r_byp ? r_byp_data : w_rd_data;

    always_comb begin
        n_sp     = r_sp;
        n_halted = r_halted;
        n_top    = r_top;
        n_below  = r_below;
        w_we     = 1'b0;
        if (w_accept) begin
            unique case (w_res.act)
                ACT_PUSH: begin
                    n_sp    = r_sp + SPW'(1);
                    n_top   = w_res.value;
                    n_below = r_top;
                    w_we    = w_flags.has_two;
                end
                ACT_POP: begin
                    n_sp    = r_sp - SPW'(1);
                    n_top   = r_below;
                    n_below = w_third;
                end
                ACT_REDUCE: begin
                    n_sp    = r_sp - SPW'(1);
                    n_top   = w_res.value;
                    n_below = w_third;
                end
                ACT_MODIFY: begin
                    n_top = w_res.value;
                end
                ACT_HALT: begin
                    n_halted = 1'b1;
                end
                default: begin
                end
            endcase
        end
        n_byp       = w_we;
        n_out_valid = w_accept || (r_out_valid && i_out_stall);
    end

    assign w_wr_addr = AW'(r_sp - SPW'(2));
    assign w_rd_addr = AW'(n_sp - SPW'(3));

    smx_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_below),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_halted    <= 1'b0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp        <= n_sp;
            r_halted    <= n_halted;
            r_byp       <= n_byp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top   <= n_top;
        r_below <= n_below;
        if (w_we) begin
            r_byp_data <= r_below;
        end
        if (w_accept) begin
            r_value  <= w_res.value;
            r_status <= w_res.status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_value;
    assign o_depth        = DepthWidth'(r_sp);
    assign o_halted       = r_halted;
    assign o_status       = r_status;

endmodule

// ===== verif/smx_result_checker.sv =====
module smx_result_checker #(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  smx_pkg::t_opcode    i_opcode,
    input  smx_pkg::t_word      i_immediate,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  smx_pkg::t_word      i_result_value,
    input  smx_pkg::t_depth     i_depth,
    input  logic                i_halted,
    input  smx_pkg::t_status    i_status,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_underflows,
    output int                  o_overflows,
    output int                  o_illegals,
    output int                  o_ignored
);
    timeunit 1ns;
    timeprecision 1ps;

    import smx_pkg::*;

    typedef struct packed {
        t_word   value;
        t_depth  depth;
        logic    halted;
        t_status status;
    } t_step_result;

    t_word        stack_mem [STACK_DEPTH];
    int unsigned  stack_count;
    logic         halt_seen;
    t_step_result pending_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_underflows = 0;
        o_overflows  = 0;
        o_illegals   = 0;
        o_ignored    = 0;
        stack_count  = 0;
        halt_seen    = 1'b0;
    end

    // Runs one instruction on the mirrored stack and returns what the block should report.
    function automatic t_step_result execute_instruction(t_opcode op, t_word imm);
        t_step_result r;
        t_word        top_word;
        t_word        below_word;
        r.value  = '0;
        r.status = ST_OK;
        if (halt_seen) begin
            r.status = ST_IGNORED;
        end else if (op > OP_HALT) begin
            r.status = ST_ILLEGAL;
        end else begin
            case (op)
                OP_PUSH: begin
                    if (stack_count >= STACK_DEPTH) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        stack_mem[stack_count] = imm;
                        stack_count++;
                        r.value = imm;
                    end
                end
                OP_POP: begin
                    if (stack_count == 0) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        stack_count--;
                        r.value = stack_mem[stack_count];
                    end
                end
                OP_ADD, OP_SUB, OP_MUL: begin
                    if (stack_count < 2) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        top_word   = stack_mem[stack_count-1];
                        below_word = stack_mem[stack_count-2];
                        if (op == OP_ADD) begin
                            r.value = below_word + top_word;
                        end else if (op == OP_SUB) begin
                            r.value = below_word - top_word;
                        end else begin
                            r.value = below_word * top_word;
                        end
                        stack_count--;
                        stack_mem[stack_count-1] = r.value;
                    end
                end
                OP_INC, OP_DEC: begin
                    if (stack_count == 0) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        top_word = stack_mem[stack_count-1];
                        r.value  = (op == OP_INC) ? top_word + 16'd1 : top_word - 16'd1;
                        stack_mem[stack_count-1] = r.value;
                    end
                end
                default: begin
                    halt_seen = 1'b1;
                end
            endcase
        end
        r.depth  = t_depth'(stack_count);
        r.halted = halt_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_step_result want;
        if (!i_rst_n) begin
            stack_count = 0;
            halt_seen   = 1'b0;
            pending_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                want = execute_instruction(i_opcode, i_immediate);
                pending_results.push_back(want);
                case (want.status)
                    ST_UNDERFLOW: o_underflows++;
                    ST_OVERFLOW:  o_overflows++;
                    ST_ILLEGAL:   o_illegals++;
                    ST_IGNORED:   o_ignored++;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: value %h depth %0d status %0d",
                           i_result_value, i_depth, i_status);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    o_checked++;
                    if (i_result_value !== want.value) begin
                        $error("result_value: expected %h, got %h", want.value, i_result_value);
                        o_fail_count++;
                    end
                    if (i_depth !== want.depth) begin
                        $error("depth: expected %0d, got %0d", want.depth, i_depth);
                        o_fail_count++;
                    end
                    if (i_halted !== want.halted) begin
                        $error("halted: expected %0d, got %0d", want.halted, i_halted);
                        o_fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== verif/tb_stack_machine_executor.sv =====
module tb_stack_machine_executor;
    timeunit 1ns;
    timeprecision 1ps;

    import smx_pkg::*;

    localparam int unsigned StackDepth = 256;
    localparam int          IdleLimit  = 2000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_opcode  opcode    = OP_PUSH;
    t_word    immediate = '0;
    logic     out_stall = 1'b0;

    logic     in_stall;
    logic     out_valid;
    t_word    result_value;
    t_depth   depth;
    logic     halted;
    t_status  status;

    int       fail_count;
    int       pending;
    int       checked;
    int       underflows;
    int       overflows;
    int       illegals;
    int       ignored;

    // While set, no gaps are inserted and no new stalls begin; one under way runs out.
    logic     no_idle = 1'b0;
    int       requests_sent = 0;
    int       stall_hold = 0;
    int       stall_roll;
    int       idle_cycles = 0;

    stack_machine_executor #(
        .STACK_DEPTH(StackDepth)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_immediate    (immediate),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_value (result_value),
        .o_depth        (depth),
        .o_halted       (halted),
        .o_status       (status)
    );

    smx_result_checker #(
        .STACK_DEPTH(StackDepth)
    ) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_immediate    (immediate),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result_value (result_value),
        .i_depth        (depth),
        .i_halted       (halted),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_underflows   (underflows),
        .o_overflows    (overflows),
        .o_illegals     (illegals),
        .o_ignored      (ignored)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Result-side backpressure: often none, mostly short stalls, a few long.
    always @(negedge clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (no_idle) begin
                out_stall = 1'b0;
            end else if (stall_roll < 55) begin
                out_stall  = 1'b0;
                stall_hold = $urandom_range(0, 6);
            end else if (stall_roll < 92) begin
                out_stall  = 1'b1;
                stall_hold = $urandom_range(0, 3);
            end else begin
                out_stall  = 1'b1;
                stall_hold = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("tb_stack_machine_executor: errors");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 25);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(t_opcode op, t_word imm);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        opcode    = op;
        immediate = imm;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        requests_sent++;
    endtask

    function automatic t_opcode random_illegal();
        return t_opcode'($urandom_range(8, 255));
    endfunction

    function automatic t_word random_word();
        return t_word'($urandom_range(0, 65535));
    endfunction

    // Balanced mix: the depth wanders near empty, so underflows show up often.
    function automatic t_opcode mixed_opcode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 36) return OP_PUSH;
        if (roll < 48) return OP_POP;
        if (roll < 56) return OP_ADD;
        if (roll < 64) return OP_SUB;
        if (roll < 72) return OP_MUL;
        if (roll < 79) return OP_INC;
        if (roll < 86) return OP_DEC;
        return random_illegal();
    endfunction

    // Mostly shrinking instructions, used to work down from a full stack.
    function automatic t_opcode draining_opcode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return OP_POP;
        if (roll < 45) return OP_ADD;
        if (roll < 65) return OP_SUB;
        if (roll < 85) return OP_MUL;
        if (roll < 90) return OP_INC;
        if (roll < 95) return OP_DEC;
        return random_illegal();
    endfunction

    initial begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Every arithmetic and pop opcode on an empty stack underflows.
        send_request(OP_POP, 16'h0000);
        send_request(OP_ADD, 16'hFFFF);
        send_request(OP_SUB, 16'h0000);
        send_request(OP_MUL, 16'hFFFF);
        send_request(OP_INC, 16'h0000);
        send_request(OP_DEC, 16'hFFFF);
        send_request(OP_PUSH, 16'hFFFF);
        send_request(OP_ADD, 16'h1234);
        send_request(OP_PUSH, 16'h0001);
        send_request(OP_ADD, 16'h0000);
        send_request(OP_DEC, 16'h0000);
        send_request(OP_INC, 16'h0000);
        send_request(OP_PUSH, 16'h0005);
        send_request(OP_SUB, 16'h0000);
        send_request(OP_PUSH, 16'hFFFF);
        send_request(OP_MUL, 16'h0000);
        send_request(OP_PUSH, 16'h8000);
        send_request(OP_PUSH, 16'h0002);
        send_request(OP_MUL, 16'h0000);
        send_request(OP_POP, 16'h0000);
        send_request(OP_POP, 16'h0000);
        send_request(OP_POP, 16'h0000);
        send_request(8'hFF, 16'hAAAA);
        send_request(8'h08, 16'h5555);
        send_request(OP_PUSH, 16'h0000);

        repeat (100) send_request(mixed_opcode(), random_word());

        // Fill to the top and push past it; the first stretch runs without idling.
        no_idle = 1'b1;
        repeat (80) send_request(OP_PUSH, random_word());
        no_idle = 1'b0;
        repeat (StackDepth + 3 - 80) send_request(OP_PUSH, random_word());

        repeat (125) send_request(draining_opcode(), random_word());
        repeat (30) send_request(mixed_opcode(), random_word());

        send_request(OP_HALT, random_word());
        repeat (12) send_request(t_opcode'($urandom_range(0, 255)), random_word());

        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests, checked %0d results.", requests_sent, checked);
        $display("Faults seen: %0d underflow, %0d overflow, %0d illegal, %0d ignored after halt.",
                 underflows, overflows, illegals, ignored);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_stack_machine_executor: clean");
        end else begin
            $display("tb_stack_machine_executor: errors");
        end
        $finish;
    end

endmodule
